// File: hw/rtl/bss_pkg.sv
// Shared definitions for the snapshot stack block: widths, codes and the
// command/status structs between controller and datapath. No dependencies.
package bss_pkg;

  localparam int BSS_MAX_ENTRIES = 16;
  localparam int BSS_TOKEN_BITS  = 32;
  localparam int RETRY_W         = 16;
  localparam int DLIM_W          = 5;
  localparam int FUNC_W          = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_BUDGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT  = 2'd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH      = 2'd0,
    FUNC_DRAW      = 2'd1,
    FUNC_SIDE_PUSH = 2'd2,
    FUNC_MERGE     = 2'd3
  } func_t;

  typedef struct packed {
    logic load_in;
    logic main_push;
    logic push_src_side;
    logic side_push;
    logic side_clear;
    logic stk_rd;
    logic ret_dec;
    logic pop;
    logic mrg_start;
    logic mrg_step;
    logic res_load;
    logic res_tok;
  } bss_cmd_t;

  typedef struct packed {
    func_t func;
    logic  stk_empty;
    logic  pop_empties;
    logic  side_empty;
    logic  ret_nz;
    logic  mrg_last;
    logic  out_free;
  } bss_sts_t;

endpackage

// File: hw/rtl/bss_ctrl.sv
// Controller state machine of the snapshot stack block.
// Depends on bss_pkg; drives bss_datapath through bss_cmd_t only.
module bss_ctrl
  import bss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  bss_sts_t sts,
  output bss_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_DCHK = 5'b00100,
    ST_DNXT = 5'b01000,
    ST_MRG  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.func)
          FUNC_PUSH: begin
            if (sts.out_free) begin
              cmd.main_push = 1'b1;
              cmd.res_load  = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          FUNC_SIDE_PUSH: begin
            if (sts.out_free) begin
              cmd.side_push = 1'b1;
              cmd.res_load  = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          FUNC_DRAW: begin
            if (sts.stk_empty) begin
              if (sts.out_free) begin
                cmd.res_load = 1'b1;
                state_nxt    = ST_IDLE;
              end
            end else begin
              cmd.stk_rd = 1'b1;
              state_nxt  = ST_DCHK;
            end
          end
          FUNC_MERGE: begin
            if (sts.side_empty) begin
              if (sts.out_free) begin
                cmd.side_clear = 1'b1;
                cmd.res_load   = 1'b1;
                state_nxt      = ST_IDLE;
              end
            end else begin
              cmd.mrg_start = 1'b1;
              state_nxt     = ST_MRG;
            end
          end
          default: ;
        endcase
      end
      ST_DCHK: begin
        if (sts.ret_nz) begin
          if (sts.out_free) begin
            cmd.ret_dec  = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_tok  = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (sts.pop_empties) begin
          if (sts.out_free) begin
            cmd.pop      = 1'b1;
            cmd.res_load = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.pop    = 1'b1;
          cmd.stk_rd = 1'b1;
          state_nxt  = ST_DNXT;
        end
      end
      ST_DNXT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_tok  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_MRG: begin
        if (sts.mrg_last) begin
          if (sts.out_free) begin
            cmd.main_push     = 1'b1;
            cmd.push_src_side = 1'b1;
            cmd.side_clear    = 1'b1;
            cmd.res_load      = 1'b1;
            state_nxt         = ST_IDLE;
          end
        end else begin
          cmd.main_push     = 1'b1;
          cmd.push_src_side = 1'b1;
          cmd.mrg_step      = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/bss_datapath.sv
// Datapath of the snapshot stack block: config registers, stack and side
// memories, pointers, fill counts and the output register. Depends on bss_pkg.
module bss_datapath
  import bss_pkg::*;
#(
  parameter int MAX_ENTRIES = BSS_MAX_ENTRIES,
  parameter int TOKEN_BITS  = BSS_TOKEN_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data,
  input  logic [((TOKEN_BITS+7)/8)*8-1:0] in_tdata,
  input  logic [FUNC_W-1:0]               in_tuser,
  input  bss_cmd_t                        cmd,
  output bss_sts_t                        sts,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [((TOKEN_BITS+8)/8)*8-1:0] out_tdata,
  output logic                            out_tuser
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W + 1 > DLIM_W) ? CNT_W + 1 : DLIM_W;
  localparam int OUT_W = ((TOKEN_BITS + 8) / 8) * 8;

  function automatic logic [IDX_W-1:0] slot_below(input logic [IDX_W-1:0] i);
    if (i == '0) return IDX_W'(MAX_ENTRIES - 1);
    return i - 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] slot_above(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(MAX_ENTRIES - 1)) return '0;
    return i + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] capped_inc(input logic [CNT_W-1:0] c,
                                                  input logic [CMP_W-1:0] lim);
    logic [CMP_W-1:0] inc;
    inc = CMP_W'(c) + 1'b1;
    if (inc > lim) return c;
    return CNT_W'(inc);
  endfunction

  logic [RETRY_W-1:0]    retry_r;
  logic [DLIM_W-1:0]     dlim_r;
  logic [CMP_W-1:0]      eff_lim;

  logic [TOKEN_BITS-1:0] stk_tok_mem [MAX_ENTRIES];
  logic [RETRY_W-1:0]    stk_ret_mem [MAX_ENTRIES];
  logic [TOKEN_BITS-1:0] side_mem    [MAX_ENTRIES];

  logic [IDX_W-1:0]      stk_top_r, stk_top_nxt;
  logic [CNT_W-1:0]      stk_cnt_r, stk_cnt_nxt;
  logic [IDX_W-1:0]      side_top_r, side_top_nxt;
  logic [CNT_W-1:0]      side_cnt_r, side_cnt_nxt;
  logic [IDX_W-1:0]      mrg_idx_r, mrg_idx_nxt;
  logic [CNT_W-1:0]      mrg_left_r, mrg_left_nxt;

  func_t                 func_r;
  logic [TOKEN_BITS-1:0] tok_in_r;
  logic [TOKEN_BITS-1:0] tok_rd_q;
  logic [RETRY_W-1:0]    ret_rd_q;
  logic [TOKEN_BITS-1:0] side_rd_q;
  logic [TOKEN_BITS-1:0] push_tok;

  logic                  out_valid_r;
  logic                  out_tv_r;
  logic [TOKEN_BITS-1:0] out_tok_r;
  logic                  out_cb_r;
  logic                  out_free;

  assign eff_lim = (CMP_W'(dlim_r) > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES)
                                                         : CMP_W'(dlim_r);
  assign push_tok = cmd.push_src_side ? side_rd_q : tok_in_r;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    stk_top_nxt = stk_top_r;
    stk_cnt_nxt = stk_cnt_r;
    if (cmd.main_push) begin
      stk_top_nxt = slot_below(stk_top_r);
      stk_cnt_nxt = capped_inc(stk_cnt_r, eff_lim);
    end else if (cmd.pop) begin
      stk_top_nxt = slot_above(stk_top_r);
      stk_cnt_nxt = stk_cnt_r - 1'b1;
    end
  end

  always_comb begin
    side_top_nxt = side_top_r;
    side_cnt_nxt = side_cnt_r;
    if (cmd.side_clear) begin
      side_top_nxt = '0;
      side_cnt_nxt = '0;
    end else if (cmd.side_push) begin
      side_top_nxt = slot_below(side_top_r);
      side_cnt_nxt = capped_inc(side_cnt_r, eff_lim);
    end
  end

  always_comb begin
    mrg_idx_nxt  = mrg_idx_r;
    mrg_left_nxt = mrg_left_r;
    if (cmd.mrg_start) begin
      mrg_idx_nxt  = side_top_r;
      mrg_left_nxt = side_cnt_r;
    end else if (cmd.mrg_step) begin
      mrg_idx_nxt  = slot_above(mrg_idx_r);
      mrg_left_nxt = mrg_left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_r     <= '0;
      dlim_r      <= '0;
      stk_top_r   <= '0;
      stk_cnt_r   <= '0;
      side_top_r  <= '0;
      side_cnt_r  <= '0;
      mrg_idx_r   <= '0;
      mrg_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RETRY_BUDGET: retry_r <= cfg_data[RETRY_W-1:0];
          CFG_DEPTH_LIMIT:  dlim_r  <= cfg_data[DLIM_W-1:0];
          default: ;
        endcase
      end
      stk_top_r  <= stk_top_nxt;
      stk_cnt_r  <= stk_cnt_nxt;
      side_top_r <= side_top_nxt;
      side_cnt_r <= side_cnt_nxt;
      mrg_idx_r  <= mrg_idx_nxt;
      mrg_left_r <= mrg_left_nxt;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r   <= func_t'(in_tuser);
      tok_in_r <= in_tdata[TOKEN_BITS-1:0];
    end
    if (cmd.main_push) begin
      stk_tok_mem[stk_top_nxt] <= push_tok;
      stk_ret_mem[stk_top_nxt] <= retry_r;
    end else if (cmd.ret_dec) begin
      stk_ret_mem[stk_top_nxt] <= ret_rd_q - 1'b1;
    end
    if (cmd.stk_rd) begin
      tok_rd_q <= stk_tok_mem[stk_top_nxt];
      ret_rd_q <= stk_ret_mem[stk_top_nxt];
    end
    if (cmd.side_push) begin
      side_mem[side_top_nxt] <= tok_in_r;
    end
    if (cmd.mrg_start || cmd.mrg_step) begin
      side_rd_q <= side_mem[mrg_idx_nxt];
    end
    if (cmd.res_load) begin
      out_tv_r  <= cmd.res_tok;
      out_tok_r <= cmd.res_tok ? tok_rd_q : '0;
      out_cb_r  <= (stk_cnt_nxt != '0);
    end
  end

  assign sts.func        = func_r;
  assign sts.stk_empty   = (stk_cnt_r == '0);
  assign sts.pop_empties = (stk_cnt_r == CNT_W'(1));
  assign sts.side_empty  = (side_cnt_r == '0);
  assign sts.ret_nz      = (ret_rd_q != '0);
  assign sts.mrg_last    = (mrg_left_r == CNT_W'(1));
  assign sts.out_free    = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_tv_r;
  assign out_tdata  = OUT_W'({out_cb_r, out_tok_r});

endmodule

// File: hw/rtl/backtrack_snapshot_stack_top.sv
// Top level of the snapshot stack block; ties bss_ctrl to bss_datapath.
// Push and side push: the result is loaded once the output register is free.
// Draw: reads the top entry unless empty; a pop to a new top also reads the next entry.
// Merge of N side entries: one side-memory read per entry.
// Result sits in an output register; the next item is taken once it is loaded.
// Reset (synchronous, rst_n low): both stacks empty, both registers zero.
module backtrack_snapshot_stack_top
  import bss_pkg::*;
#(
  parameter int MAX_ENTRIES = BSS_MAX_ENTRIES,
  parameter int TOKEN_BITS  = BSS_TOKEN_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // snapshot_token
  input  logic [((TOKEN_BITS+7)/8)*8-1:0] in_tdata,
  // func
  input  logic [FUNC_W-1:0]               in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // token_out, can_backtrack
  output logic [((TOKEN_BITS+8)/8)*8-1:0] out_tdata,
  // token_valid
  output logic                            out_tuser
);

  bss_cmd_t cmd;
  bss_sts_t sts;

  assign cfg_ready = 1'b1;

  bss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bss_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TOKEN_BITS  (TOKEN_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
